[rtl/fpw_pkg.sv]
// Shared constants, types and state codes of the fuel pulse width block.
`default_nettype none

package fpw_pkg;

    // Engine constants.
    localparam int STOICH_X100   = 1470;
    localparam int BANKS         = 2;
    localparam int MAX_WIDTH_US  = 25000;
    localparam int CRANK_AFR     = 1200;

    // Divider sizing: dividend req*ve*stoich, divisor afr*1000.
    localparam int DVD_W = 39;
    localparam int DSR_W = 22;
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);

    // Closed-loop trim denominator.
    localparam int TRIM_DEN   = BANKS * 32768;
    localparam int TRIM_SHIFT = $clog2(BANKS) + 15;

    // Configuration register indexes.
    localparam logic [2:0] REG_BASE_FUEL  = 3'd0;
    localparam logic [2:0] REG_MIN_SPEED  = 3'd1;
    localparam logic [2:0] REG_MAX_SPEED  = 3'd2;
    localparam logic [2:0] REG_MAX_PRESS  = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN  = 3'd4;
    localparam logic [2:0] REG_INT_GAIN   = 3'd5;
    localparam logic [2:0] REG_TRIM_LIMIT = 3'd6;
    localparam logic [2:0] REG_CRANK_W    = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE_RV,
        ST_BASE_ST,
        ST_BASE_AF,
        ST_DIV,
        ST_WARM,
        ST_SCALE,
        ST_ACCEL,
        ST_TRIM_I,
        ST_TRIM_P,
        ST_APPLY,
        ST_FINISH
    } fpw_state_t;

endpackage

`default_nettype wire

[rtl/fpw_divider.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module fpw_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [fpw_pkg::DVD_W-1:0]  dividend,
    input  wire logic [fpw_pkg::DSR_W-1:0]  divisor,
    output logic                            done,
    output logic [fpw_pkg::DVD_W-1:0]       quotient
);
    import fpw_pkg::*;

    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DSR_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DSR_W:0]       trial;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = DIV_CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

[rtl/fuel_pulse_width_with_o2_trim.sv]
// Top level: injector pulse width with warm-up, acceleration and oxygen trim.
//
// Usage. One request on the input channel carries one engine update; the
// block answers each with exactly one request on the output channel. Both
// channels use valid and stall: a request moves at a rising edge at which
// valid is high and stall is low. The user must write the configuration
// registers through cfg_write, cfg_index and cfg_data only while the block
// is idle; the block does not enforce this. A cranking update skips all
// arithmetic, and closed loop adds the trim steps. The time to a result is
// set by the shared 32x18 multiplier, used at most once per step of the
// sequencer, and chiefly by the bit-serial divider that forms the base
// width. One update is worked at a time. A finished result waits in the
// output register; while the receiver stalls, a new update may be accepted
// and computed, and it then waits until the output register frees up.
// Reset clears the sequencer and the engine state (throttle history,
// enrichment, trims) and loads the configuration registers with defaults.
`default_nettype none

module fuel_pulse_width_with_o2_trim (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // Input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [13:0]        engine_speed,
    input  wire logic [11:0]        manifold_pressure,
    input  wire logic [9:0]         throttle_pos,
    input  wire logic signed [9:0]  coolant_temp,
    input  wire logic               cranking,
    input  wire logic [11:0]        vol_eff,
    input  wire logic [11:0]        table_afr,
    input  wire logic [11:0]        sensed_afr_a,
    input  wire logic [11:0]        sensed_afr_b,
    // Output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [14:0]             pulse_width_us,
    output logic [11:0]             goal_afr,
    output logic                    in_closed_loop,
    output logic signed [15:0]      trim_a,
    output logic signed [15:0]      trim_b,
    output logic [12:0]             accel_add_us,
    // Configuration port
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);
    import fpw_pkg::*;

    // Symmetric clamp of a wide signed value to plus or minus the limit.
    function automatic logic signed [15:0] clamp_sym(input logic signed [22:0] v,
                                                     input logic [14:0] lim);
        logic signed [22:0] hi;
        hi = $signed({8'b0, lim});
        if (v > hi)
            clamp_sym = $signed({1'b0, lim});
        else if (v < -hi)
            clamp_sym = -$signed({1'b0, lim});
        else
            clamp_sym = v[15:0];
    endfunction

    // Configuration registers.
    logic [15:0] base_fuel_reg;
    logic [13:0] min_speed_reg;
    logic [13:0] max_speed_reg;
    logic [11:0] max_press_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] int_gain_reg;
    logic [14:0] trim_limit_reg;
    logic [14:0] crank_width_reg;

    // Sequencer and working registers.
    fpw_state_t         state_reg, state_next;
    logic [31:0]        width_reg, width_next;
    logic [27:0]        rv_reg, rv_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [15:0]        warm_reg, warm_next;
    logic [12:0]        enrich_reg, enrich_next;
    logic               loop_reg, loop_next;
    logic               crank_reg, crank_next;
    logic               bank_reg, bank_next;

    // Engine state kept between updates.
    logic [9:0]         last_thr_reg, last_thr_next;
    logic [12:0]        accel_left_reg, accel_left_next;
    logic signed [15:0] trim_int_reg [2];
    logic signed [15:0] trim_int_next [2];
    logic signed [15:0] trim_val_reg [2];
    logic signed [15:0] trim_val_next [2];

    // Latched request fields.
    logic [13:0]        speed_reg;
    logic [11:0]        press_reg;
    logic [9:0]         thr_reg;
    logic signed [9:0]  temp_reg;
    logic [11:0]        ve_reg;
    logic [11:0]        afr_reg;
    logic [11:0]        sensed_a_reg;
    logic [11:0]        sensed_b_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [14:0]        pw_out_reg;
    logic [11:0]        goal_out_reg;
    logic               loop_out_reg;
    logic signed [15:0] trim_a_out_reg;
    logic signed [15:0] trim_b_out_reg;
    logic [12:0]        accel_out_reg;
    logic               out_load;

    // Shared multiplier.
    logic [31:0]        mul_a;
    logic [17:0]        mul_b;
    logic [49:0]        mul_p;

    // Divider handshake.
    logic               div_start;
    logic               div_done;
    logic [DVD_W-1:0]   div_quot;

    // Helper nets.
    logic               in_acc;
    logic [11:0]        afr_eff;
    logic signed [10:0] dt_full;
    logic               temp_hot;
    logic               temp_cold;
    logic signed [10:0] thr_delta;
    logic               thr_rise;
    logic [12:0]        thr_accel;
    logic [12:0]        accel_cur;
    logic [12:0]        accel_dec;
    logic               loop_win;
    logic [11:0]        sensed_sel;
    logic signed [12:0] err;
    logic [12:0]        err_abs;
    logic [20:0]        gain_rnd;
    logic signed [22:0] gain_term;
    logic signed [22:0] trim_sum;
    logic signed [17:0] bank_sum;
    logic [17:0]        trim_num;

    assign mul_p  = 50'(mul_a) * 50'(mul_b);
    assign in_acc = in_valid && !in_stall;

    assign afr_eff   = (afr_reg == 12'd0) ? 12'd1 : afr_reg;
    assign dt_full   = 11'sd160 - $signed({temp_reg[9], temp_reg});
    assign temp_hot  = temp_reg >= 10'sd160;
    assign temp_cold = temp_reg <= 10'sd32;

    // Throttle rise in 0.1 % steps; a rise of more than 5 % arms 5 us per step.
    assign thr_delta = $signed({1'b0, thr_reg}) - $signed({1'b0, last_thr_reg});
    assign thr_rise  = thr_delta > 11'sd50;
    assign thr_accel = 13'({1'b0, thr_delta[9:0], 2'b00}) + 13'(thr_delta[9:0]);
    assign accel_cur = thr_rise ? thr_accel : accel_left_reg;
    // Four fifths by reciprocal: 52429 / 2^18 is exact for these magnitudes.
    assign accel_dec = 13'(mul_p >> 18);

    assign loop_win = (speed_reg >= min_speed_reg) && (speed_reg <= max_speed_reg) &&
                      (press_reg <= max_press_reg);

    // Error magnitude and sign; rounding is half away from zero.
    assign sensed_sel = bank_reg ? sensed_b_reg : sensed_a_reg;
    assign err        = $signed({1'b0, afr_reg}) - $signed({1'b0, sensed_sel});
    assign err_abs    = err[12] ? 13'(-err) : 13'(err);
    assign gain_rnd   = 21'((mul_p + 50'd128) >> 8);
    assign gain_term  = err[12] ? -$signed({2'b0, gain_rnd}) : $signed({2'b0, gain_rnd});

    assign bank_sum = 18'(trim_val_reg[0]) + ((BANKS > 1) ? 18'(trim_val_reg[1]) : 18'sd0);
    assign trim_num = 18'(TRIM_DEN) + 18'(bank_sum);

    always_comb
    begin
        state_next      = state_reg;
        width_next      = width_reg;
        rv_next         = rv_reg;
        dvd_next        = dvd_reg;
        warm_next       = warm_reg;
        enrich_next     = enrich_reg;
        loop_next       = loop_reg;
        crank_next      = crank_reg;
        bank_next       = bank_reg;
        last_thr_next   = last_thr_reg;
        accel_left_next = accel_left_reg;
        trim_int_next   = trim_int_reg;
        trim_val_next   = trim_val_reg;
        mul_a           = '0;
        mul_b           = '0;
        div_start       = 1'b0;
        trim_sum        = '0;
        out_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    crank_next = cranking;
                    if (cranking)
                    begin
                        width_next    = 32'(crank_width_reg);
                        enrich_next   = '0;
                        loop_next     = 1'b0;
                        last_thr_next = throttle_pos;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_BASE_RV;
                    end
                end
            end
            ST_BASE_RV:
            begin
                mul_a      = 32'(base_fuel_reg);
                mul_b      = 18'(ve_reg);
                rv_next    = mul_p[27:0];
                state_next = ST_BASE_ST;
            end
            ST_BASE_ST:
            begin
                mul_a      = 32'(rv_reg);
                mul_b      = 18'(STOICH_X100);
                dvd_next   = mul_p[DVD_W-1:0];
                state_next = ST_BASE_AF;
            end
            ST_BASE_AF:
            begin
                mul_a      = 32'(afr_eff);
                mul_b      = 18'd1000;
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    width_next = 32'(div_quot);
                    state_next = ST_WARM;
                end
            end
            ST_WARM:
            begin
                mul_a = 32'(dt_full[7:0]);
                mul_b = 18'd13107;
                if (temp_hot)
                    warm_next = 16'd32768;
                else if (temp_cold)
                    warm_next = 16'd45875;
                else
                    warm_next = 16'd32768 + 16'(mul_p >> 7);
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_a      = width_reg;
                mul_b      = 18'(warm_reg);
                width_next = 32'((mul_p + 50'd16384) >> 15);
                state_next = ST_ACCEL;
            end
            ST_ACCEL:
            begin
                mul_a           = 32'({accel_cur, 2'b00});
                mul_b           = 18'd52429;
                accel_left_next = (accel_dec < 13'd10) ? 13'd0 : accel_dec;
                enrich_next     = accel_cur;
                width_next      = width_reg + 32'(accel_cur);
                last_thr_next   = thr_reg;
                loop_next       = loop_win;
                bank_next       = 1'b0;
                state_next      = loop_win ? ST_TRIM_I : ST_FINISH;
            end
            ST_TRIM_I:
            begin
                mul_a    = 32'(err_abs[11:0]);
                mul_b    = 18'(int_gain_reg);
                trim_sum = gain_term + 23'(trim_int_reg[bank_reg]);
                trim_int_next[bank_reg] = clamp_sym(trim_sum, trim_limit_reg);
                state_next = ST_TRIM_P;
            end
            ST_TRIM_P:
            begin
                mul_a    = 32'(err_abs[11:0]);
                mul_b    = 18'(prop_gain_reg);
                trim_sum = gain_term + 23'(trim_int_reg[bank_reg]);
                trim_val_next[bank_reg] = clamp_sym(trim_sum, trim_limit_reg);
                if (bank_reg == 1'(BANKS - 1))
                begin
                    state_next = ST_APPLY;
                end
                else
                begin
                    bank_next  = 1'b1;
                    state_next = ST_TRIM_I;
                end
            end
            ST_APPLY:
            begin
                mul_a      = width_reg;
                mul_b      = trim_num;
                width_next = 32'((mul_p + 50'(TRIM_DEN / 2)) >> TRIM_SHIFT);
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    fpw_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_reg),
        .divisor  (mul_p[DSR_W-1:0]),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control state, engine history and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            bank_reg        <= 1'b0;
            last_thr_reg    <= '0;
            accel_left_reg  <= '0;
            trim_int_reg[0] <= '0;
            trim_int_reg[1] <= '0;
            trim_val_reg[0] <= '0;
            trim_val_reg[1] <= '0;
            base_fuel_reg   <= 16'd0;
            min_speed_reg   <= 14'd800;
            max_speed_reg   <= 14'd4000;
            max_press_reg   <= 12'd800;
            prop_gain_reg   <= 16'd4194;
            int_gain_reg    <= 16'd839;
            trim_limit_reg  <= 15'd6554;
            crank_width_reg <= 15'd5000;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            bank_reg       <= bank_next;
            last_thr_reg   <= last_thr_next;
            accel_left_reg <= accel_left_next;
            trim_int_reg   <= trim_int_next;
            trim_val_reg   <= trim_val_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_BASE_FUEL:  base_fuel_reg   <= cfg_data;
                    REG_MIN_SPEED:  min_speed_reg   <= cfg_data[13:0];
                    REG_MAX_SPEED:  max_speed_reg   <= cfg_data[13:0];
                    REG_MAX_PRESS:  max_press_reg   <= cfg_data[11:0];
                    REG_PROP_GAIN:  prop_gain_reg   <= cfg_data;
                    REG_INT_GAIN:   int_gain_reg    <= cfg_data;
                    REG_TRIM_LIMIT: trim_limit_reg  <= cfg_data[14:0];
                    REG_CRANK_W:    crank_width_reg <= cfg_data[14:0];
                    default:        ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        rv_reg     <= rv_next;
        dvd_reg    <= dvd_next;
        warm_reg   <= warm_next;
        enrich_reg <= enrich_next;
        loop_reg   <= loop_next;
        crank_reg  <= crank_next;
        if (in_acc)
        begin
            speed_reg    <= engine_speed;
            press_reg    <= manifold_pressure;
            thr_reg      <= throttle_pos;
            temp_reg     <= coolant_temp;
            ve_reg       <= vol_eff;
            afr_reg      <= table_afr;
            sensed_a_reg <= sensed_afr_a;
            sensed_b_reg <= sensed_afr_b;
        end
        if (out_load)
        begin
            pw_out_reg     <= (width_reg > 32'(MAX_WIDTH_US)) ? 15'(MAX_WIDTH_US)
                                                              : width_reg[14:0];
            goal_out_reg   <= crank_reg ? 12'(CRANK_AFR) : afr_reg;
            loop_out_reg   <= loop_reg;
            trim_a_out_reg <= trim_val_reg[0];
            trim_b_out_reg <= (BANKS > 1) ? trim_val_reg[1] : 16'sd0;
            accel_out_reg  <= enrich_reg;
        end
    end

    assign in_stall       = state_reg != ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign pulse_width_us = pw_out_reg;
    assign goal_afr       = goal_out_reg;
    assign in_closed_loop = loop_out_reg;
    assign trim_a         = trim_a_out_reg;
    assign trim_b         = trim_b_out_reg;
    assign accel_add_us   = accel_out_reg;

    // The delivered width never exceeds the injector limit.
    a_width_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pulse_width_us <= 15'(MAX_WIDTH_US))
        else $error("pulse width above saturation limit");

    // The divider only finishes while the sequencer waits for it.
    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    // A cranking request skips all arithmetic.
    a_crank_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cranking) |=> state_reg == ST_FINISH)
        else $error("cranking request did not go straight to finish");

    // A finished result with a free output register is shown next cycle.
    a_finish_show: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !out_valid) |=> out_valid)
        else $error("finished result not presented");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the fuel pulse width block with oxygen trim.
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import fpw_pkg::*;

    // One engine update as it is driven onto the input channel.
    typedef struct packed {
        logic [13:0]       speed;
        logic [11:0]       press;
        logic [9:0]        thr;
        logic signed [9:0] temp;
        logic              crank;
        logic [11:0]       ve;
        logic [11:0]       afr;
        logic [11:0]       sens_a;
        logic [11:0]       sens_b;
    } update_t;

    // One injector result as the block reports it.
    typedef struct packed {
        logic [14:0]        width;
        logic [11:0]        goal;
        logic               closed;
        logic signed [15:0] trim_a;
        logic signed [15:0] trim_b;
        logic [12:0]        accel;
    } pulse_t;

    // A row of the directed table: the update, whether a result is typed in,
    // and that result.
    typedef struct {
        update_t upd;
        bit      fixed;
        pulse_t  res;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [13:0] engine_speed;
    logic [11:0] manifold_pressure;
    logic [9:0]  throttle_pos;
    logic signed [9:0] coolant_temp;
    logic        cranking;
    logic [11:0] vol_eff;
    logic [11:0] table_afr;
    logic [11:0] sensed_afr_a;
    logic [11:0] sensed_afr_b;

    logic        out_valid;
    logic        out_stall;
    logic [14:0] pulse_width_us;
    logic [11:0] goal_afr;
    logic        in_closed_loop;
    logic signed [15:0] trim_a;
    logic signed [15:0] trim_b;
    logic [12:0] accel_add_us;

    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    fuel_pulse_width_with_o2_trim DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .engine_speed      (engine_speed),
        .manifold_pressure (manifold_pressure),
        .throttle_pos      (throttle_pos),
        .coolant_temp      (coolant_temp),
        .cranking          (cranking),
        .vol_eff           (vol_eff),
        .table_afr         (table_afr),
        .sensed_afr_a      (sensed_afr_a),
        .sensed_afr_b      (sensed_afr_b),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pulse_width_us    (pulse_width_us),
        .goal_afr          (goal_afr),
        .in_closed_loop    (in_closed_loop),
        .trim_a            (trim_a),
        .trim_b            (trim_b),
        .accel_add_us      (accel_add_us),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // The predictor keeps its own copy of the configuration registers.
    logic [15:0] base_fuel;
    logic [13:0] min_speed;
    logic [13:0] max_speed;
    logic [11:0] max_press;
    logic [15:0] prop_gain;
    logic [15:0] int_gain;
    logic [14:0] trim_lim;
    logic [14:0] crank_width;

    // And its own copy of the engine state.
    logic [9:0]  prev_thr;
    logic [12:0] accel_left;
    int          bank_integ [2];
    int          bank_trim [2];

    pulse_t expected_pulses [$];
    int     error_count;
    bit     idle_enabled;
    int     quiet_cycles;

    // Clock: 8 ns period.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Rounding of a signed quotient, half away from zero.
    function automatic longint round_away(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    // Symmetric clamp to plus or minus the trim limit.
    function automatic int clamp_trim(input longint v, input int lim);
        if (v > lim)
            return lim;
        if (v < -longint'(lim))
            return -lim;
        return int'(v);
    endfunction

    // Works out the injector result of one update and advances the state.
    function automatic pulse_t predict_pulse(input update_t u);
        pulse_t      p;
        longint      width;
        longint      warm;
        longint      divisor;
        longint      e;
        longint      sum;
        longint      lim;
        int          t;
        int          d;
        logic [12:0] enrich;
        bit          closed;
        int          sensed [2];

        p = '0;
        if (u.crank)
        begin
            prev_thr = u.thr;
            p.width  = (crank_width > MAX_WIDTH_US) ? 15'(MAX_WIDTH_US) : crank_width;
            p.goal   = 12'(CRANK_AFR);
            p.trim_a = 16'(bank_trim[0]);
            p.trim_b = 16'(bank_trim[1]);
            return p;
        end

        divisor = (u.afr == 0 ? 1 : longint'(u.afr)) * 1000;
        width = (longint'(base_fuel) * longint'(u.ve) * STOICH_X100) / divisor;
        if (width > 64'h7FFF_FFFF)
            width = 64'h7FFF_FFFF;

        t = int'(u.temp);
        if (t >= 160)
            warm = 32768;
        else if (t <= 32)
            warm = 45875;
        else
            warm = 32768 + (longint'(160 - t) * 13107) / 128;
        width = (width * warm + 16384) >>> 15;

        // A rise of more than 5 % of throttle rearms the enrichment.
        d = int'(u.thr) - int'(prev_thr);
        if (d > 50)
            accel_left = 13'(d * 5);
        enrich = '0;
        if (accel_left > 0)
        begin
            enrich = accel_left;
            accel_left = 13'((int'(accel_left) * 4) / 5);
            if (accel_left < 10)
                accel_left = '0;
        end
        width += enrich;

        closed = (u.speed >= min_speed) && (u.speed <= max_speed) &&
                 (u.press <= max_press);
        if (closed)
        begin
            lim = trim_lim;
            sensed[0] = u.sens_a;
            sensed[1] = u.sens_b;
            sum = 0;
            for (int b = 0; b < BANKS; b++)
            begin
                e = longint'(u.afr) - sensed[b];
                bank_integ[b] = clamp_trim(bank_integ[b] +
                                round_away(e * int_gain, 256), int'(lim));
                bank_trim[b] = clamp_trim(round_away(e * prop_gain, 256) +
                               bank_integ[b], int'(lim));
                sum += bank_trim[b];
            end
            width = (width * (TRIM_DEN + sum) + TRIM_DEN / 2) / TRIM_DEN;
        end

        if (width > MAX_WIDTH_US)
            width = MAX_WIDTH_US;
        prev_thr = u.thr;

        p.width  = 15'(width);
        p.goal   = u.afr;
        p.closed = closed;
        p.trim_a = 16'(bank_trim[0]);
        p.trim_b = 16'(bank_trim[1]);
        p.accel  = enrich;
        return p;
    endfunction

    // Writes one configuration register in the block and in the predictor.
    // The write enable stays high for back-to-back writes; the caller drops it.
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_BASE_FUEL:  base_fuel   = value;
            REG_MIN_SPEED:  min_speed   = value[13:0];
            REG_MAX_SPEED:  max_speed   = value[13:0];
            REG_MAX_PRESS:  max_press   = value[11:0];
            REG_PROP_GAIN:  prop_gain   = value;
            REG_INT_GAIN:   int_gain    = value;
            REG_TRIM_LIMIT: trim_lim    = value[14:0];
            REG_CRANK_W:    crank_width = value[14:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] rf, input logic [15:0] mn,
                             input logic [15:0] mx, input logic [15:0] mp,
                             input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] lm, input logic [15:0] cw);
        write_register(REG_BASE_FUEL, rf);
        write_register(REG_MIN_SPEED, mn);
        write_register(REG_MAX_SPEED, mx);
        write_register(REG_MAX_PRESS, mp);
        write_register(REG_PROP_GAIN, kp);
        write_register(REG_INT_GAIN, ki);
        write_register(REG_TRIM_LIMIT, lm);
        write_register(REG_CRANK_W, cw);
        cfg_write <= 1'b0;
    endtask

    // Drops the input valid, waits until every expected result has come
    // back, then lets the block settle before the configuration is touched.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // Offers one request and holds it until accepted; a random idle burst may
    // come first. Valid stays high afterwards so that requests can follow
    // back to back; wait_drained drops it.
    task automatic send_update(input update_t u);
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        engine_speed      <= u.speed;
        manifold_pressure <= u.press;
        throttle_pos      <= u.thr;
        coolant_temp      <= u.temp;
        cranking          <= u.crank;
        vol_eff           <= u.ve;
        table_afr         <= u.afr;
        sensed_afr_a      <= u.sens_a;
        sensed_afr_b      <= u.sens_b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Random update. Most fall near the closed-loop window with sensible table
    // values; the rest cover the whole field ranges, pressure only to 2550.
    function automatic update_t random_update();
        update_t u;
        if ($urandom_range(0, 3) != 0)
        begin
            u.speed  = 14'($urandom_range(600, 4500));
            u.press  = 12'($urandom_range(200, 1000));
            u.ve     = 12'($urandom_range(300, 1100));
            u.afr    = 12'($urandom_range(1100, 1600));
            u.sens_a = 12'(int'(u.afr) + $urandom_range(0, 400) - 200);
            u.sens_b = 12'(int'(u.afr) + $urandom_range(0, 400) - 200);
            u.temp   = 10'($urandom_range(0, 220));
        end
        else
        begin
            u.speed  = 14'($urandom_range(0, 16383));
            u.press  = 12'($urandom_range(0, 2550));
            u.ve     = 12'($urandom_range(0, 4095));
            u.afr    = 12'($urandom_range(0, 4095));
            u.sens_a = 12'($urandom_range(0, 4095));
            u.sens_b = 12'($urandom_range(0, 4095));
            u.temp   = 10'($urandom_range(0, 1023));
        end
        u.thr   = 10'($urandom_range(0, 1023));
        u.crank = ($urandom_range(0, 15) == 0);
        return u;
    endfunction

    // Every request accepted on the input side is predicted at once, so the
    // expected results are queued in input order.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            expected_pulses.push_back(predict_pulse({engine_speed, manifold_pressure,
                throttle_pos, coolant_temp, cranking, vol_eff, table_afr,
                sensed_afr_a, sensed_afr_b}));
    end

    // Result checker: each accepted result is compared with the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin
        pulse_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_pulses.size() == 0)
            begin
                $error("unexpected result width=%0d", pulse_width_us);
                error_count++;
            end
            else
            begin
                want = expected_pulses.pop_front();
                if (pulse_width_us !== want.width)
                begin
                    $error("pulse_width_us: expected %0d, got %0d", want.width, pulse_width_us);
                    error_count++;
                end
                if (goal_afr !== want.goal)
                begin
                    $error("goal_afr: expected %0d, got %0d", want.goal, goal_afr);
                    error_count++;
                end
                if (in_closed_loop !== want.closed)
                begin
                    $error("in_closed_loop: expected %0d, got %0d", want.closed,
                           in_closed_loop);
                    error_count++;
                end
                if (trim_a !== want.trim_a)
                begin
                    $error("trim_a: expected %0d, got %0d", want.trim_a, trim_a);
                    error_count++;
                end
                if (trim_b !== want.trim_b)
                begin
                    $error("trim_b: expected %0d, got %0d", want.trim_b, trim_b);
                    error_count++;
                end
                if (accel_add_us !== want.accel)
                begin
                    $error("accel_add_us: expected %0d, got %0d", want.accel, accel_add_us);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stalls in random bursts while idling is enabled.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Directed table. Rows with fixed set carry a result typed in by hand.
    row_t directed [$];

    task automatic add_row(input update_t u, input bit fixed, input pulse_t r);
        row_t row;
        row.upd = u;
        row.fixed = fixed;
        row.res = r;
        directed.push_back(row);
    endtask

    task automatic run_directed();
        pulse_t      got;
        logic [9:0]  saved_thr;
        logic [12:0] saved_accel;
        int          saved_integ [2];
        int          saved_trim [2];
        foreach (directed[i])
        begin
            if (directed[i].fixed)
            begin
                // A hand-typed result must agree with the predictor, which
                // then checks the block as usual. The dry run must leave the
                // engine state as it found it, so that state is put back.
                saved_thr   = prev_thr;
                saved_accel = accel_left;
                saved_integ = bank_integ;
                saved_trim  = bank_trim;
                got = predict_pulse(directed[i].upd);
                if (got !== directed[i].res)
                begin
                    $error("directed row %0d: typed result disagrees with prediction", i);
                    error_count++;
                end
                prev_thr   = saved_thr;
                accel_left = saved_accel;
                bank_integ = saved_integ;
                bank_trim  = saved_trim;
            end
            send_update(directed[i].upd);
        end
    endtask

    initial
    begin
        update_t u;
        pulse_t  r;
        int      phase;

        rst_n = 1'b0;
        in_valid = 1'b0;
        engine_speed = '0;
        manifold_pressure = '0;
        throttle_pos = '0;
        coolant_temp = '0;
        cranking = 1'b0;
        vol_eff = '0;
        table_afr = '0;
        sensed_afr_a = '0;
        sensed_afr_b = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        idle_enabled = 1'b0;
        quiet_cycles = 0;

        base_fuel = 0;
        min_speed = 800;
        max_speed = 4000;
        max_press = 800;
        prop_gain = 4194;
        int_gain = 839;
        trim_lim = 6554;
        crank_width = 5000;
        prev_thr = '0;
        accel_left = '0;
        bank_integ = '{0, 0};
        bank_trim = '{0, 0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset the fuel constant is zero, so an open-loop
        // update outside the window gives zero width.
        u = '{speed: 0, press: 0, thr: 0, temp: 200, crank: 0, ve: 1000,
              afr: 1470, sens_a: 0, sens_b: 0};
        r = '{width: 0, goal: 1470, closed: 0, trim_a: 0, trim_b: 0, accel: 0};
        add_row(u, 1'b1, r);
        // Cranking at reset: the default cranking width and AFR 12.00.
        u = '{speed: 200, press: 1000, thr: 0, temp: -64, crank: 1, ve: 0,
              afr: 100, sens_a: 4095, sens_b: 4095};
        r = '{width: 5000, goal: 1200, closed: 0, trim_a: 0, trim_b: 0, accel: 0};
        add_row(u, 1'b1, r);
        run_directed();
        wait_drained();

        write_all(16'd6000, 16'd800, 16'd4000, 16'd800, 16'd4194, 16'd839,
                  16'd6554, 16'd25000);
        directed.delete();
        // Field extremes, cold and hot coolant, zero table AFR, a throttle
        // step that arms the enrichment and its decay, the window edges.
        add_row('{0, 0, 0, 10'sd511, 0, 0, 0, 0, 0}, 0, '0);
        add_row('{16383, 2550, 1000, -10'sd64, 0, 2550, 4095, 4095, 4095}, 0, '0);
        add_row('{1000, 500, 0, 10'sd32, 0, 4095, 0, 0, 4095}, 0, '0);
        add_row('{800, 800, 1000, 10'sd33, 0, 800, 1470, 1300, 1600}, 0, '0);
        add_row('{4000, 800, 1000, 10'sd100, 0, 800, 1470, 1470, 1470}, 0, '0);
        add_row('{4001, 800, 900, 10'sd159, 0, 800, 1470, 1000, 1000}, 0, '0);
        add_row('{799, 801, 0, 10'sd160, 0, 800, 1470, 1000, 1000}, 0, '0);
        add_row('{2000, 300, 51, 10'sd161, 0, 800, 1300, 4095, 0}, 0, '0);
        add_row('{2000, 300, 1023, 10'sd80, 0, 800, 1300, 0, 4095}, 0, '0);
        for (int k = 0; k < 6; k++)
            add_row('{2000, 300, 1023, 10'sd80, 0, 800, 1300, 1300, 1300}, 0, '0);
        add_row('{2000, 300, 1023, 10'sd80, 1, 800, 1300, 1300, 1300}, 0, '0);
        add_row('{2000, 300, 0, 10'sd80, 0, 800, 1300, 1300, 1300}, 0, '0);
        run_directed();
        wait_drained();

        // Random phases under several register settings, extremes included.
        idle_enabled = 1'b1;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_all(16'd6000, 16'd800, 16'd4000, 16'd800, 16'd4194, 16'd839,
                             16'd6554, 16'd5000);
                1: write_all(16'hFFFF, 16'd0, 16'd16383, 16'd2550, 16'hFFFF, 16'hFFFF,
                             16'd32767, 16'd32767);
                2: write_all(16'd0, 16'd16383, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: write_all(16'd12000, 16'd500, 16'd5000, 16'd1500, 16'd20000, 16'd5000,
                             16'd3000, 16'd3000);
                default: write_all(16'd8000, 16'd600, 16'd4500, 16'd1000, 16'd4194,
                                   16'd839, 16'd6554, 16'd4000);
            endcase
            // The last phase runs with no idling on either side.
            if (phase == 4)
                idle_enabled = 1'b0;
            repeat (150) send_update(random_update());
            wait_drained();
        end

        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/fpw_pkg.sv
rtl/fpw_divider.sv
rtl/fuel_pulse_width_with_o2_trim.sv
tb/tb.sv
